/* src/tsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

    // Multiplier of the 32-bit multiplicative hash.
    localparam logic [31:0] HASH_MULT  = 32'h61C8_8647;
    // Value of the cookie seed after reset.
    localparam logic [31:0] SEED_RESET = 32'd42;
    // TCP flag masks.
    localparam logic [7:0]  FLAG_SYN   = 8'h02;
    localparam logic [7:0]  FLAG_ACK   = 8'h10;

    typedef enum logic [1:0] {
        VERDICT_PASS = 2'd0,
        VERDICT_DROP = 2'd1,
        VERDICT_TX   = 2'd2
    } verdict_t;

    // What the pipeline does with an item.
    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_SYN  = 2'd1,
        MODE_ACK  = 2'd2
    } mode_t;

    // Item after the first hash.
    typedef struct packed {
        mode_t       mode;
        logic [31:0] s;
        logic [31:0] c;
        logic [31:0] e;
        logic [31:0] h1;
        logic [15:0] port;
    } front_t;

    // Item after the base hash.
    typedef struct packed {
        mode_t       mode;
        logic [31:0] s;
        logic [31:0] c;
        logic [31:0] e;
        logic [31:0] b;
    } base_t;

    // Item after the two epoch hashes.
    typedef struct packed {
        mode_t       mode;
        logic [31:0] s;
        logic [31:0] c;
        logic [31:0] eh0;
        logic [31:0] eh1;
    } epoch_t;

    // H(x) = x * HASH_MULT mod 2^32.
    function automatic logic [31:0] mix32(input logic [31:0] x);
        mix32 = x * HASH_MULT;
    endfunction

endpackage

`default_nettype wire

/* src/tcp_syn_cookie_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Stateless TCP SYN-cookie filter. Each input transaction carries one parsed
// TCP/IPv4 header summary and yields exactly one result transaction, in order:
// a SYN without ACK is answered with a transmit verdict, the cookie as reply
// sequence number and the sequence number plus one as reply acknowledgment;
// an ACK without SYN passes when its acknowledgment minus one matches the cookie
// for the current or the previous epoch, and is dropped otherwise; everything
// else passes. The destination address and port do not enter the cookie.
// The block takes one transaction per cycle while its output is not stalled.
// Three register stages hold the three chained 32-bit hash multiplies (first
// hash, base hash, the two epoch hashes) and a fourth holds the compare and
// the output. The seed is written through the cfg port, which is always ready;
// write it only while no transaction is in flight.

module tcp_syn_cookie_filter
    import tsc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Seed write.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data,
    // Header summaries.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // src_addr[31:0], dst_addr[63:32], src_port[79:64], dst_port[95:80],
    // seq_num[127:96], ack_num[159:128], tcp_flags[167:160], epoch[199:168]
    input  wire logic [199:0] s_axis_tdata,
    // is_tcp_ipv4[0]
    input  wire logic         s_axis_tuser,
    // Verdicts.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // reply_seq[31:0], reply_ack[63:32]
    output logic [63:0]       m_axis_tdata,
    // verdict[1:0]
    output logic [1:0]        m_axis_tuser
);

    logic [31:0] seed_reg;
    logic        front_valid;
    logic        front_ready;
    front_t      front_item;
    logic        core_valid;
    logic        core_ready;
    epoch_t      core_item;
    verdict_t    verdict;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;

    // Seed register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    // Decode and first hash.
    tsc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed        (seed_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_is_tcp   (s_axis_tuser),
        .in_src_addr (s_axis_tdata[31:0]),
        .in_src_port (s_axis_tdata[79:64]),
        .in_seq      (s_axis_tdata[127:96]),
        .in_ack      (s_axis_tdata[159:128]),
        .in_flags    (s_axis_tdata[167:160]),
        .in_epoch    (s_axis_tdata[199:168]),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_item    (front_item)
    );

    // Base and epoch hashes.
    tsc_hash_core u_hash_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    // Cookie check and output register.
    tsc_verdict u_verdict (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (core_valid),
        .in_ready      (core_ready),
        .in_item       (core_item),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_verdict   (verdict),
        .out_reply_seq (reply_seq),
        .out_reply_ack (reply_ack)
    );

    assign m_axis_tdata = {reply_ack, reply_seq};
    assign m_axis_tuser = verdict;

endmodule

`default_nettype wire

/* src/tsc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsc_front
    import tsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] seed,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        in_is_tcp,
    input  wire logic [31:0] in_src_addr,
    input  wire logic [15:0] in_src_port,
    input  wire logic [31:0] in_seq,
    input  wire logic [31:0] in_ack,
    input  wire logic [7:0]  in_flags,
    input  wire logic [31:0] in_epoch,
    output logic             out_valid,
    input  wire logic        out_ready,
    output front_t           out_item
);

    logic        valid_reg;
    front_t      item_reg;
    front_t      item_next;
    mode_t       mode;
    logic [7:0]  sel;

    // Classify the item from the protocol flag and the SYN and ACK bits.
    always_comb
    begin
        sel = in_flags & (FLAG_SYN | FLAG_ACK);
        mode = MODE_PASS;
        if (in_is_tcp)
        begin
            if (sel == FLAG_SYN)
            begin
                mode = MODE_SYN;
            end
            else if (sel == FLAG_ACK)
            begin
                mode = MODE_ACK;
            end
        end
    end

    // Sequence number that enters the hash, the cookie to check and the first hash.
    always_comb
    begin
        item_next.mode = mode;
        item_next.s    = (mode == MODE_ACK) ? (in_seq - 32'd1) : in_seq;
        item_next.c    = (in_ack - 32'd1) - item_next.s;
        item_next.e    = in_epoch;
        item_next.h1   = mix32(seed | in_src_addr);
        item_next.port = in_src_port;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Stage register: valid bit with reset, payload without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    // A non-TCP transaction must leave this stage marked to pass.
    a_non_tcp_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_is_tcp) |=> (valid_reg && item_reg.mode == MODE_PASS))
        else $error("non-TCP item not marked to pass");

endmodule

`default_nettype wire

/* src/tsc_hash_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsc_hash_core
    import tsc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire front_t in_item,
    output logic        out_valid,
    input  wire logic   out_ready,
    output epoch_t      out_item
);

    logic   a_valid_reg;
    base_t  a_item_reg;
    base_t  a_item_next;
    logic   a_ready;
    logic   b_valid_reg;
    epoch_t b_item_reg;
    epoch_t b_item_next;
    logic   b_ready;

    // Base hash over the first hash and the packed sequence and port word.
    always_comb
    begin
        a_item_next.mode = in_item.mode;
        a_item_next.s    = in_item.s;
        a_item_next.c    = in_item.c;
        a_item_next.e    = in_item.e;
        a_item_next.b    = mix32(in_item.h1 | {in_item.s[15:0], in_item.port});
    end

    // Epoch hashes for the current and the previous epoch.
    always_comb
    begin
        b_item_next.mode = a_item_reg.mode;
        b_item_next.s    = a_item_reg.s;
        b_item_next.c    = a_item_reg.c;
        b_item_next.eh0  = mix32(a_item_reg.b | a_item_reg.e);
        b_item_next.eh1  = mix32(a_item_reg.b | (a_item_reg.e - 32'd1));
    end

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_item_reg <= a_item_next;
        end
        if (a_valid_reg && b_ready)
        begin
            b_item_reg <= b_item_next;
        end
    end

    // An accepted item is held in the first stage on the next cycle.
    a_stage_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> a_valid_reg)
        else $error("accepted item lost in base hash stage");

    // An item moved on from the first stage lands in the second.
    a_stage_moved: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_ready) |=> b_valid_reg)
        else $error("item lost between hash stages");

endmodule

`default_nettype wire

/* src/tsc_verdict.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsc_verdict
    import tsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire epoch_t      in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output verdict_t         out_verdict,
    output logic [31:0]      out_reply_seq,
    output logic [31:0]      out_reply_ack
);

    logic        valid_reg;
    verdict_t    verdict_reg;
    verdict_t    verdict_next;
    logic [31:0] rseq_reg;
    logic [31:0] rseq_next;
    logic [31:0] rack_reg;
    logic [31:0] rack_next;
    logic        cookie_ok;

    // The cookie is valid for the current or the previous epoch.
    assign cookie_ok = (in_item.c == in_item.eh0) || (in_item.c == in_item.eh1);

    // Verdict and reply numbers.
    always_comb
    begin
        verdict_next = VERDICT_PASS;
        rseq_next    = 32'd0;
        rack_next    = 32'd0;
        unique case (in_item.mode)
            MODE_SYN:
            begin
                verdict_next = VERDICT_TX;
                rseq_next    = in_item.s + in_item.eh0;
                rack_next    = in_item.s + 32'd1;
            end
            MODE_ACK:
            begin
                verdict_next = cookie_ok ? VERDICT_PASS : VERDICT_DROP;
            end
            default:
            begin
                verdict_next = VERDICT_PASS;
            end
        endcase
    end

    assign in_ready      = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign out_verdict   = verdict_reg;
    assign out_reply_seq = rseq_reg;
    assign out_reply_ack = rack_reg;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            verdict_reg <= verdict_next;
            rseq_reg    <= rseq_next;
            rack_reg    <= rack_next;
        end
    end

    // Reply numbers are zero unless a SYN-ACK is to be sent.
    a_zero_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && verdict_reg != VERDICT_TX) |-> (rseq_reg == 32'd0 && rack_reg == 32'd0))
        else $error("reply numbers set without transmit verdict");

    // An item marked to pass leaves with a pass verdict.
    a_pass_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.mode == MODE_PASS)
            |=> (valid_reg && verdict_reg == VERDICT_PASS))
        else $error("pass item given another verdict");

endmodule

`default_nettype wire

/* test/tb_tcp_syn_cookie_filter.sv */
`timescale 1ns / 1ps

module tb_tcp_syn_cookie_filter;
    import tsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 165;
    localparam int HOLD_CYCLES    = 80;

    // One parsed header summary as the block sees it.
    typedef struct {
        logic        is_tcp;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [31:0] epoch;
    } header_t;

    // One verdict transaction as the block should deliver it.
    typedef struct {
        verdict_t    verdict;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
    } verdict_rec_t;

    // Predicts the verdict of each accepted header and checks delivered verdicts in order.
    class cookie_scoreboard;
        logic [31:0]  seed;
        verdict_rec_t verdict_q[$];
        int           errors;

        function new();
            seed   = SEED_RESET;
            errors = 0;
        endfunction

        function logic [31:0] scramble(input logic [31:0] x);
            return x * HASH_MULT;
        endfunction

        // Cookie for sequence number s at epoch e; only the source side enters it.
        function logic [31:0] cookie_for(input logic [31:0] saddr, input logic [15:0] sport,
                                         input logic [31:0] s, input logic [31:0] e);
            logic [31:0] first;
            logic [31:0] base;
            first = scramble(seed | saddr);
            base  = scramble(first | {s[15:0], sport});
            return s + scramble(base | e);
        endfunction

        function void note_header(input header_t h);
            verdict_rec_t rec;
            logic [7:0]   sel;
            logic [31:0]  s;
            logic [31:0]  c;
            rec.verdict   = VERDICT_PASS;
            rec.reply_seq = '0;
            rec.reply_ack = '0;
            sel = h.flags & (FLAG_SYN | FLAG_ACK);
            if (h.is_tcp && sel == FLAG_SYN)
            begin
                rec.verdict   = VERDICT_TX;
                rec.reply_seq = cookie_for(h.saddr, h.sport, h.seq, h.epoch);
                rec.reply_ack = h.seq + 32'd1;
            end
            else if (h.is_tcp && sel == FLAG_ACK)
            begin
                // The client acknowledges cookie + 1 with sequence number s + 1.
                s = h.seq - 32'd1;
                c = h.ack - 32'd1;
                if (c != cookie_for(h.saddr, h.sport, s, h.epoch) &&
                    c != cookie_for(h.saddr, h.sport, s, h.epoch - 32'd1))
                    rec.verdict = VERDICT_DROP;
            end
            verdict_q.push_back(rec);
        endfunction

        function void check_verdict(input logic [1:0] verdict, input logic [31:0] reply_seq,
                                    input logic [31:0] reply_ack);
            verdict_rec_t rec;
            if (verdict_q.size() == 0)
            begin
                $error("verdict: none expected, got %0d", verdict);
                errors++;
                return;
            end
            rec = verdict_q.pop_front();
            if (verdict !== rec.verdict)
            begin
                $error("verdict: expected %0d, got %0d", rec.verdict, verdict);
                errors++;
            end
            if (reply_seq !== rec.reply_seq)
            begin
                $error("reply_seq: expected %08h, got %08h", rec.reply_seq, reply_seq);
                errors++;
            end
            if (reply_ack !== rec.reply_ack)
            begin
                $error("reply_ack: expected %08h, got %08h", rec.reply_ack, reply_ack);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    cookie_scoreboard sb;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               rx_hold = 0;
    int               quiet_cycles = 0;

    tcp_syn_cookie_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Verdict side: check each transaction, then decide whether to stall the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_verdict(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold       <= rx_hold - 1;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_tcp_syn_cookie_filter: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic header_t make_header(input logic is_tcp, input logic [31:0] saddr,
                                            input logic [31:0] daddr, input logic [15:0] sport,
                                            input logic [15:0] dport, input logic [31:0] seq,
                                            input logic [31:0] ack, input logic [7:0] flags,
                                            input logic [31:0] epoch);
        header_t h;
        h.is_tcp = is_tcp;
        h.saddr  = saddr;
        h.daddr  = daddr;
        h.sport  = sport;
        h.dport  = dport;
        h.seq    = seq;
        h.ack    = ack;
        h.flags  = flags;
        h.epoch  = epoch;
        return h;
    endfunction

    // The ACK a client sends back after a SYN with sequence number s answered at epoch e_cookie.
    function automatic header_t client_ack(input logic [31:0] saddr, input logic [31:0] daddr,
                                           input logic [15:0] sport, input logic [15:0] dport,
                                           input logic [31:0] s, input logic [31:0] e_cookie,
                                           input logic [31:0] e_sent, input logic [7:0] flags);
        return make_header(1'b1, saddr, daddr, sport, dport, s + 32'd1,
                           sb.cookie_for(saddr, sport, s, e_cookie) + 32'd1, flags, e_sent);
    endfunction

    // Mostly well-formed SYNs and handshake ACKs, with broken ACKs and noise mixed in.
    function automatic header_t random_header();
        header_t     h;
        int          kind;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] s;
        logic [31:0] e;
        logic [7:0]  flags;
        kind  = $urandom_range(99);
        saddr = $urandom;
        daddr = $urandom;
        sport = 16'($urandom);
        dport = 16'($urandom);
        s     = $urandom;
        e     = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
        flags = 8'($urandom);
        if (kind < 25)
            h = make_header(1'b1, saddr, daddr, sport, dport, s, $urandom,
                            (flags | FLAG_SYN) & ~FLAG_ACK, e);
        else if (kind < 60)
            h = client_ack(saddr, daddr, sport, dport, s, e,
                           $urandom_range(1) ? e : e + 32'd1, (flags | FLAG_ACK) & ~FLAG_SYN);
        else if (kind < 72)
        begin
            h = client_ack(saddr, daddr, sport, dport, s, e, e,
                           (flags | FLAG_ACK) & ~FLAG_SYN);
            case ($urandom_range(3))
                0: h.ack   = h.ack ^ (32'd1 << $urandom_range(31));
                1: h.epoch = e + 32'd2;
                2: h.sport = h.sport ^ (16'd1 << $urandom_range(15));
                default: h.seq = h.seq ^ (32'd1 << $urandom_range(31));
            endcase
        end
        else if (kind < 82)
            h = make_header(1'b1, saddr, daddr, sport, dport, s, $urandom,
                            $urandom_range(1) ? (flags | FLAG_SYN | FLAG_ACK)
                                              : (flags & ~(FLAG_SYN | FLAG_ACK)), e);
        else if (kind < 90)
            h = make_header(1'b0, saddr, daddr, sport, dport, s, $urandom, flags, e);
        else
            h = make_header(1'($urandom_range(1)), saddr, daddr, sport, dport, s, $urandom,
                            flags, e);
        return h;
    endfunction

    // Idle cycles before the next header, one draw per cycle.
    function automatic int header_gap();
        int g;
        g = 0;
        while ($urandom_range(99) < tx_idle_pct && g < 40)
            g++;
        return g;
    endfunction

    task automatic send_header(input header_t h, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= h.is_tcp;
        s_axis_tdata  <= {h.epoch, h.flags, h.ack, h.seq, h.dport, h.sport, h.daddr, h.saddr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_header(h);
    endtask

    // Stop offering headers until every verdict has come back, then let the pipeline empty.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.seed = value;
    endtask

    initial
    begin
        header_t     h;
        logic [31:0] seed_value;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed headers under the reset seed.
        send_header(make_header(1'b0, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80,
                                32'h1111_2222, 32'd0, FLAG_SYN, 32'd7), 0);
        send_header(make_header(1'b0, '0, '0, '0, '0, '0, '0, '0, '0), 0);
        send_header(make_header(1'b1, '0, '0, '0, '0, '0, '0, FLAG_SYN, '0), 0);
        send_header(make_header(1'b1, '1, '1, '1, '1, '1, '1, ~FLAG_ACK, '1), 0);
        send_header(make_header(1'b1, 32'hC0A8_0101, 32'hC0A8_0102, 16'd40000, 16'd443,
                                32'h8000_0000, 32'h1234_5678, 8'hFF, 32'd100), 0);
        send_header(make_header(1'b1, 32'hC0A8_0101, 32'hC0A8_0102, 16'd40000, 16'd443,
                                32'h8000_0000, 32'h1234_5678, 8'h00, 32'd100), 0);
        send_header(make_header(1'b1, 32'hC0A8_0101, 32'hC0A8_0102, 16'd40000, 16'd443,
                                32'h8000_0000, 32'h1234_5678, ~(FLAG_SYN | FLAG_ACK),
                                32'd100), 0);
        // A SYN and the matching ACK in the same epoch, with other destination fields.
        send_header(make_header(1'b1, 32'h0102_0304, 32'h0506_0708, 16'd5555, 16'd22,
                                32'hDEAD_BEEF, 32'd0, FLAG_SYN, 32'd500), 0);
        send_header(client_ack(32'h0102_0304, 32'hFFFF_0000, 16'd5555, 16'd8080,
                               32'hDEAD_BEEF, 32'd500, 32'd500, FLAG_ACK), 0);
        // ACK one epoch late, and late across the epoch wrap.
        send_header(client_ack(32'h0102_0304, 32'h0506_0708, 16'd5555, 16'd22,
                               32'hDEAD_BEEF, 32'd500, 32'd501, FLAG_ACK), 0);
        send_header(client_ack(32'h7F00_0001, 32'h7F00_0001, 16'd1, 16'd1,
                               32'h0000_FFFF, 32'hFFFF_FFFF, 32'd0, FLAG_ACK), 0);
        // Sequence number that wraps when one is taken off.
        send_header(client_ack(32'h0A0B_0C0D, 32'h0, 16'd9999, 16'd0,
                               32'hFFFF_FFFF, 32'd3, 32'd3, FLAG_ACK), 0);
        // Address, port, sequence and epoch fields at their maximum with every other flag set.
        send_header(client_ack('1, '1, '1, '1, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                               ~FLAG_SYN), 0);
        // Two epochs late: must be dropped.
        send_header(client_ack(32'h0102_0304, 32'h0506_0708, 16'd5555, 16'd22,
                               32'hDEAD_BEEF, 32'd500, 32'd502, FLAG_ACK), 0);
        // Acknowledgment off by one bit.
        h = client_ack(32'h0102_0304, 32'h0506_0708, 16'd5555, 16'd22,
                       32'h0BAD_F00D, 32'd9, 32'd9, FLAG_ACK);
        h.ack = h.ack ^ 32'd1;
        send_header(h, 0);
        send_header(make_header(1'b1, '0, '0, '0, '0, '0, '0, FLAG_ACK, '0), 0);
        send_header(make_header(1'b0, '1, '1, '1, '1, '1, '1, '1, '1), 0);
        wait_drained();

        // Random phases, each under its own seed, in pairs that share an idling pattern.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: seed_value = 32'h0000_0000;
                1: seed_value = 32'hFFFF_FFFF;
                3: seed_value = 32'h8000_0001;
                default: seed_value = $urandom;
            endcase
            write_seed(seed_value);
            tx_idle_pct = (phase < 2) ? 6 : (phase < 4) ? 78 : 0;
            rx_idle_pct <= (phase < 2) ? 78 : (phase < 4) ? 6 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Long receiver hold-off while headers keep coming.
                if (k == 40 && (phase == 0 || phase == 4))
                    rx_hold <= HOLD_CYCLES;
                if (k == 100 && phase == 4)
                    wait_drained();
                send_header(random_header(), header_gap());
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_tcp_syn_cookie_filter: done, clean");
        else
            $display("tb_tcp_syn_cookie_filter: done, errors");
        $finish;
    end

endmodule
